// ----- sv/isqrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root package
// Widths, step count and shared types for the digit-by-digit square root.
// ----------------------------------------------------------------------------
package isqrt_pkg;

  localparam int INPUT_WIDTH       = 31;
  localparam int ROOT_WIDTH        = 16;
  localparam int FIRST_TRIAL_SHIFT = ((INPUT_WIDTH - 1) / 2) * 2;
  localparam int NUM_STEPS         = FIRST_TRIAL_SHIFT / 2 + 1;

  typedef logic [INPUT_WIDTH-1:0] word_t;
  typedef logic [ROOT_WIDTH-1:0]  root_t;

  typedef struct packed {
    word_t rem;
    word_t root;
  } stage_t;

  function automatic word_t trial_bit(input int step);
    word_t one;
    one = word_t'(1);
    return one << (FIRST_TRIAL_SHIFT - 2 * step);
  endfunction

  function automatic root_t to_root(input word_t w);
    return root_t'(w);
  endfunction

endpackage

// ----- sv/isqrt_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root pipeline stage
// One restoring step (trial compare and subtract) followed by a register.
// ----------------------------------------------------------------------------
module isqrt_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  input  isqrt_pkg::stage_t up_data,
  input  isqrt_pkg::word_t  trial,
  output logic              up_ready,
  output logic              dn_valid,
  output isqrt_pkg::stage_t dn_data,
  input  logic              dn_ready
);
  import isqrt_pkg::*;

  logic                 valid_r;
  stage_t               data_r;
  stage_t               data_nxt;
  logic [INPUT_WIDTH:0] cand;

  always_comb begin
    cand = {1'b0, up_data.root} + {1'b0, trial};
    if ({1'b0, up_data.rem} >= cand) begin
      data_nxt.rem  = up_data.rem - cand[INPUT_WIDTH-1:0];
      data_nxt.root = (up_data.root >> 1) + trial;
    end else begin
      data_nxt.rem  = up_data.rem;
      data_nxt.root = up_data.root >> 1;
    end
  end

  assign up_ready = !valid_r || dn_ready;

  // advance when the register is empty or its request leaves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// ----- sv/integer_square_root.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root
// One restoring step per register stage. Throughput: one request per
// cycle; a stalled output holds its stage while empty stages upstream still
// fill. Reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module integer_square_root (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  isqrt_pkg::word_t in_radicand,
  output logic             out_valid,
  input  logic             out_stall,
  output isqrt_pkg::root_t out_root
);
  import isqrt_pkg::*;

  logic [NUM_STEPS:0] valid_w;
  logic [NUM_STEPS:0] ready_w;
  stage_t             data_w [NUM_STEPS+1];

  assign valid_w[0]      = in_valid;
  assign data_w[0].rem   = in_radicand;
  assign data_w[0].root  = '0;
  assign in_stall        = !ready_w[0];
  assign ready_w[NUM_STEPS] = !out_stall;

  for (genvar g = 0; g < NUM_STEPS; g++) begin : g_stage
    isqrt_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (valid_w[g]),
      .up_data  (data_w[g]),
      .trial    (trial_bit(g)),
      .up_ready (ready_w[g]),
      .dn_valid (valid_w[g+1]),
      .dn_data  (data_w[g+1]),
      .dn_ready (ready_w[g+1])
    );
  end

  assign out_valid = valid_w[NUM_STEPS];
  assign out_root  = to_root(data_w[NUM_STEPS].root);

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, data_w[NUM_STEPS].rem} <= {data_w[NUM_STEPS].root, 1'b0}))
    else $error("final remainder exceeds twice the root");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> valid_w[1])
    else $error("accepted request lost at first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ($countones(valid_w[NUM_STEPS:1]) == NUM_STEPS))
    else $error("input stalled while a stage is empty");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer square root testbench
// Sends radicands through the pipelined square root and predicts the floor
// root of each accepted request with an independent digit-by-digit
// calculation. Results are checked in order against the queue of pending
// roots. Random radicands, some near perfect squares, are sent under three
// idle/stall patterns; edge values go first in the first and third.
// ----------------------------------------------------------------------------
module tb;

  import isqrt_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = NUM_STEPS * 4;
  localparam int ITEMS_PER_PHASE = 165;

  typedef struct {
    word_t radicand;
    root_t root;
  } pending_root_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_radicand;
  logic  out_valid;
  logic  out_stall;
  root_t out_root;

  pending_root_t pending_roots[$];
  int unsigned   source_idle_pct;
  int unsigned   sink_stall_pct;
  int unsigned   error_count;
  int unsigned   cycle_count;

  integer_square_root u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_radicand (in_radicand),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_root    (out_root)
  );

  always #CLK_HALF clk = ~clk;

  function automatic root_t floor_root(input word_t radicand);
    logic [63:0] remainder;
    logic [63:0] partial;
    logic [63:0] trial;
    logic [63:0] candidate;
    remainder = 64'(radicand);
    partial   = '0;
    trial     = 64'd1 << FIRST_TRIAL_SHIFT;
    while (trial != 0) begin
      candidate = partial + trial;
      if (remainder >= candidate) begin
        remainder = remainder - candidate;
        partial   = (partial >> 1) + trial;
      end else begin
        partial = partial >> 1;
      end
      trial = trial >> 2;
    end
    return root_t'(partial);
  endfunction

  // Predict every accepted request.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      pending_roots.push_back('{radicand: in_radicand, root: floor_root(in_radicand)});
    end
  end

  always @(posedge clk) begin
    pending_root_t head;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_roots.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual root %0d", $time, out_root);
      end else begin
        head = pending_roots.pop_front();
        if (out_root !== head.root) begin
          error_count++;
          $display("%0t: root mismatch for radicand %0d: expected %0d, actual %0d",
                   $time, head.radicand, head.root, out_root);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("integer_square_root regression: fail");
      $finish;
    end
  end

  task automatic send_radicand(input word_t value);
    @(negedge clk);
    while ($urandom_range(99) < source_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_radicand <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the source until every pending root has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_values();
    word_t edge_values[$];
    edge_values = '{0, 1, 2, 3, 4, 5, 8, 9, 15, 16, 24, 25, 99, 100,
                    65535, 65536, 1 << 30, (1 << 30) - 1,
                    2147395600, 2147395599, 2147483647, 2147483646,
                    31'h55555555, 31'h2AAAAAAA};
    foreach (edge_values[i]) send_radicand(edge_values[i]);
  endtask

  function automatic word_t near_square_radicand();
    longint unsigned base;
    longint unsigned value;
    int unsigned     k;
    k    = $urandom_range(46340);
    base = longint'(k) * longint'(k);
    if (k > 0 && $urandom_range(1) == 0) begin
      value = base - 1;
    end else begin
      value = base + $urandom_range(2 * k);
    end
    if (value > 64'h7FFF_FFFF) value = 64'h7FFF_FFFF;
    return word_t'(value);
  endfunction

  task automatic test_random_radicands(input int unsigned count);
    word_t value;
    repeat (count) begin
      case ($urandom_range(2))
        0: value = word_t'($urandom);
        1: value = word_t'($urandom) >> $urandom_range(INPUT_WIDTH - 1);
        default: value = near_square_radicand();
      endcase
      send_radicand(value);
    end
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_radicand     = '0;
    out_stall       = 1'b0;
    source_idle_pct = 0;
    sink_stall_pct  = 0;
    error_count     = 0;
    cycle_count     = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    source_idle_pct = 31;
    sink_stall_pct  = 51;
    test_edge_values();
    test_random_radicands(ITEMS_PER_PHASE);
    wait_drained();

    source_idle_pct = 51;
    sink_stall_pct  = 31;
    test_random_radicands(ITEMS_PER_PHASE);
    wait_drained();

    source_idle_pct = 0;
    sink_stall_pct  = 0;
    test_edge_values();
    test_random_radicands(ITEMS_PER_PHASE);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("integer_square_root regression: pass");
    end else begin
      $display("integer_square_root regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/isqrt_pkg.sv
sv/isqrt_stage.sv
sv/integer_square_root.sv
bench/tb.sv
